### sv/step_sequencer_record_player_core_assert.svh
// Assertion macros for the step sequencer core.
// Both expect clk and rst_n in the scope of the use.
`ifndef STEP_SEQUENCER_RECORD_PLAYER_CORE_ASSERT_SVH
`define STEP_SEQUENCER_RECORD_PLAYER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SSRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ssrp_pkg.sv
`default_nettype none

package ssrp_pkg;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] key_value;
    logic       voice_muted;
  } ssrp_in_t;

  typedef struct packed {
    logic       note_valid;
    logic [7:0] note_key;
    logic       mute_on;
    logic       mute_off;
    logic [1:0] play_state;
    logic       programming;
  } ssrp_out_t;

  localparam logic [3:0] ACT_TICK      = 4'd0;
  localparam logic [3:0] ACT_START     = 4'd1;
  localparam logic [3:0] ACT_STOP      = 4'd2;
  localparam logic [3:0] ACT_PAUSE     = 4'd3;
  localparam logic [3:0] ACT_CLEAR     = 4'd4;
  localparam logic [3:0] ACT_PROG_BEG  = 4'd5;
  localparam logic [3:0] ACT_PROG_KEY  = 4'd6;
  localparam logic [3:0] ACT_BUMP      = 4'd7;
  localparam logic [3:0] ACT_PROG_END  = 4'd8;

  localparam logic [7:0] TOK_REST   = 8'd253;
  localparam logic [7:0] TOK_UNMUTE = 8'd254;
  localparam logic [7:0] TOK_END    = 8'd255;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_PAUSED = 2'd2;

  localparam logic [15:0] TPB_RESET = 16'd8680;
  localparam logic [7:0]  TPE_RESET = 8'd128;

  localparam logic REG_TPB = 1'b0;
  localparam logic REG_TPE = 1'b1;

endpackage

`default_nettype wire

### sv/ssrp_ram.sv
`default_nettype none

module ssrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/step_sequencer_record_player_core.sv
// Channel  | Direction | Handshake            | Beat contents
// in_      | input     | in_valid / in_ready  | ssrp_in_t: action, key, voice muted flag
// out_     | output    | out_valid / out_ready| ssrp_out_t: note, mute commands, status
// cfg_     | input     | cfg_we (no wait)     | index 0 ticks per beat, 1 ticks per event
//
// One beat is taken at a time, only in the idle state; a finished result waits in the
// output register while the next beat is accepted.
// Simple actions go straight to the output step, a tick passes a counting step first, and a
// program key may add a rest, its length and an unmute before the key. Record tokens are read
// through the store's registered read port, and a note or rest token is followed by its beat count.
// Synchronous active-low reset; no clearing pass: entry 0 carries its own written flag.
`default_nettype none

`include "step_sequencer_record_player_core_assert.svh"

module step_sequencer_record_player_core #(
  parameter int SEQ_LEN = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ssrp_pkg::ssrp_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ssrp_pkg::ssrp_out_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  localparam int AW = $clog2(SEQ_LEN);
  localparam int RW = $clog2(SEQ_LEN + 2);
  localparam logic [RW-1:0] READS_MAX = RW'(SEQ_LEN + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(SEQ_LEN - 1);
  localparam logic [7:0]    LEN8      = 8'(SEQ_LEN);
  localparam logic [7:0]    KEY_LIMIT = 8'(SEQ_LEN - 3);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_TICK  = 11'b000_0000_0010,
    S_FETCH = 11'b000_0000_0100,
    S_TOKEN = 11'b000_0000_1000,
    S_LEN   = 11'b000_0001_0000,
    S_CLOSE = 11'b000_0010_0000,
    S_RLEN  = 11'b000_0100_0000,
    S_UNM   = 11'b000_1000_0000,
    S_KEY   = 11'b001_0000_0000,
    S_END   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]    act_r, act_nxt;
  logic [7:0]    key_r, key_nxt;
  logic          muted_r, muted_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] ri_r, ri_nxt;
  logic [15:0]   bc_r, bc_nxt;
  logic [7:0]    bl_r, bl_nxt;
  logic          prog_r, prog_nxt;
  logic [7:0]    wi_r, wi_nxt;
  logic [7:0]    nl_r, nl_nxt;
  logic [15:0]   tpb_r, tpb_nxt;
  logic [7:0]    tpe_r, tpe_nxt;
  logic          e0v_r, e0v_nxt;
  logic [RW-1:0] reads_r, reads_nxt;
  logic          ovr_r, ovr_nxt;
  logic          start_chk_r, start_chk_nxt;
  logic          nv_r, nv_nxt;
  logic [7:0]    nkey_r, nkey_nxt;
  logic          mon_r, mon_nxt;
  logic          moff_r, moff_nxt;
  logic          out_valid_r, out_valid_nxt;
  ssrp_pkg::ssrp_out_t out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0]    tok;
  logic [AW-1:0] ri_inc;
  logic [15:0]   tpe_ext;
  logic [15:0]   tick_reload;
  logic [7:0]    bl_dec;
  logic          wr_ok;
  logic          in_acc;

  ssrp_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry 0 reads as the end token until it has been written since reset or clear.
  assign tok         = ovr_r ? ssrp_pkg::TOK_END : ram_rdata;
  assign ri_inc      = (ri_r == LAST_IDX) ? '0 : ri_r + AW'(1);
  assign tpe_ext     = {8'd0, tpe_r};
  assign tick_reload = bc_r + tpb_r - tpe_ext;
  assign bl_dec      = bl_r - 8'd1;
  assign wr_ok       = (wi_r < LEN8);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    muted_nxt     = muted_r;
    mode_nxt      = mode_r;
    ri_nxt        = ri_r;
    bc_nxt        = bc_r;
    bl_nxt        = bl_r;
    prog_nxt      = prog_r;
    wi_nxt        = wi_r;
    nl_nxt        = nl_r;
    tpb_nxt       = tpb_r;
    tpe_nxt       = tpe_r;
    e0v_nxt       = e0v_r;
    reads_nxt     = reads_r;
    ovr_nxt       = ovr_r;
    start_chk_nxt = start_chk_r;
    nv_nxt        = nv_r;
    nkey_nxt      = nkey_r;
    mon_nxt       = mon_r;
    moff_nxt      = moff_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = wi_r[AW-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = ri_r;

    if (cfg_we) begin
      unique case (cfg_index)
        ssrp_pkg::REG_TPB: tpb_nxt = cfg_wdata;
        ssrp_pkg::REG_TPE: tpe_nxt = cfg_wdata[7:0];
        default:           tpe_nxt = tpe_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt       = in_data.action;
          key_nxt       = in_data.key_value;
          muted_nxt     = in_data.voice_muted;
          nv_nxt        = 1'b0;
          nkey_nxt      = 8'd0;
          mon_nxt       = 1'b0;
          moff_nxt      = 1'b0;
          start_chk_nxt = 1'b0;
          state_nxt     = S_DONE;
          unique case (in_data.action)
            ssrp_pkg::ACT_TICK: begin
              if (mode_r == ssrp_pkg::MODE_ON) begin
                state_nxt = S_TICK;
              end
            end
            ssrp_pkg::ACT_START: begin
              mode_nxt      = ssrp_pkg::MODE_ON;
              ri_nxt        = '0;
              reads_nxt     = '0;
              start_chk_nxt = 1'b1;
              bc_nxt        = tpb_r;
              state_nxt     = S_FETCH;
            end
            ssrp_pkg::ACT_STOP: begin
              mode_nxt = ssrp_pkg::MODE_OFF;
            end
            ssrp_pkg::ACT_PAUSE: begin
              if (mode_r == ssrp_pkg::MODE_ON) begin
                mode_nxt = ssrp_pkg::MODE_PAUSED;
              end else if (mode_r == ssrp_pkg::MODE_PAUSED) begin
                mode_nxt = ssrp_pkg::MODE_ON;
              end
            end
            ssrp_pkg::ACT_CLEAR: begin
              mode_nxt = ssrp_pkg::MODE_OFF;
              e0v_nxt  = 1'b0;
              tpb_nxt  = ssrp_pkg::TPB_RESET;
            end
            ssrp_pkg::ACT_PROG_BEG: begin
              mode_nxt = ssrp_pkg::MODE_OFF;
              prog_nxt = 1'b1;
              wi_nxt   = 8'd0;
              nl_nxt   = 8'd0;
            end
            ssrp_pkg::ACT_PROG_KEY, ssrp_pkg::ACT_PROG_END: begin
              if (prog_r) begin
                state_nxt = S_CLOSE;
              end
            end
            ssrp_pkg::ACT_BUMP: begin
              if (prog_r) begin
                nl_nxt = nl_r + 8'd1;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_TICK: begin
        state_nxt = S_DONE;
        if (bc_r <= tpe_ext) begin
          bc_nxt = tick_reload;
          bl_nxt = bl_dec;
          if (bl_dec == 8'd0) begin
            reads_nxt = '0;
            state_nxt = S_FETCH;
          end
        end else begin
          bc_nxt = bc_r - tpe_ext;
        end
      end

      S_FETCH: begin
        if (reads_r >= READS_MAX) begin
          mode_nxt  = ssrp_pkg::MODE_OFF;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ovr_nxt   = (ri_r == '0) && !e0v_r;
          ri_nxt    = ri_inc;
          reads_nxt = reads_r + RW'(1);
          state_nxt = S_TOKEN;
        end
      end

      S_TOKEN: begin
        // The first token of a start is entry 0: a leading rest mutes the voice.
        start_chk_nxt = 1'b0;
        if (start_chk_r && tok == ssrp_pkg::TOK_REST && !muted_r) begin
          mon_nxt = 1'b1;
        end
        if (tok == ssrp_pkg::TOK_UNMUTE) begin
          moff_nxt  = 1'b1;
          state_nxt = S_FETCH;
        end else if (tok == ssrp_pkg::TOK_END) begin
          if (ri_r > AW'(1)) begin
            ri_nxt    = '0;
            state_nxt = S_FETCH;
          end else begin
            mode_nxt  = ssrp_pkg::MODE_OFF;
            state_nxt = S_DONE;
          end
        end else begin
          if (tok != ssrp_pkg::TOK_REST) begin
            nv_nxt   = 1'b1;
            nkey_nxt = tok;
          end
          ram_re    = 1'b1;
          ovr_nxt   = (ri_r == '0) && !e0v_r;
          ri_nxt    = ri_inc;
          state_nxt = S_LEN;
        end
      end

      S_LEN: begin
        bl_nxt    = tok;
        state_nxt = S_DONE;
      end

      S_CLOSE: begin
        state_nxt = (act_r == ssrp_pkg::ACT_PROG_KEY) ? S_KEY : S_END;
        if (wi_r != 8'd0) begin
          ram_we    = wr_ok;
          ram_wdata = nl_r;
          wi_nxt    = wi_r + 8'd1;
        end else if (act_r == ssrp_pkg::ACT_PROG_KEY && nl_r != 8'd0) begin
          // A program that opens with a pause gets a rest and an unmute first.
          ram_we    = wr_ok;
          ram_wdata = ssrp_pkg::TOK_REST;
          wi_nxt    = wi_r + 8'd1;
          state_nxt = S_RLEN;
        end
      end

      S_RLEN: begin
        ram_we    = wr_ok;
        ram_wdata = nl_r;
        wi_nxt    = wi_r + 8'd1;
        state_nxt = S_UNM;
      end

      S_UNM: begin
        ram_we    = wr_ok;
        ram_wdata = ssrp_pkg::TOK_UNMUTE;
        wi_nxt    = wi_r + 8'd1;
        state_nxt = S_KEY;
      end

      S_KEY: begin
        ram_we    = wr_ok;
        state_nxt = S_DONE;
        if (wi_r > KEY_LIMIT) begin
          ram_wdata = ssrp_pkg::TOK_END;
          prog_nxt  = 1'b0;
        end else begin
          ram_wdata = key_r;
          wi_nxt    = wi_r + 8'd1;
          nl_nxt    = 8'd1;
        end
      end

      S_END: begin
        ram_we    = wr_ok;
        ram_wdata = ssrp_pkg::TOK_END;
        prog_nxt  = 1'b0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.note_valid  = nv_r;
          out_data_nxt.note_key    = nkey_r;
          out_data_nxt.mute_on     = mon_r;
          out_data_nxt.mute_off    = moff_r;
          out_data_nxt.play_state  = mode_r;
          out_data_nxt.programming = prog_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (ram_we && ram_waddr == '0) begin
      e0v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= ssrp_pkg::MODE_OFF;
      ri_r        <= '0;
      bc_r        <= 16'd0;
      bl_r        <= 8'd0;
      prog_r      <= 1'b0;
      wi_r        <= 8'd0;
      nl_r        <= 8'd0;
      tpb_r       <= ssrp_pkg::TPB_RESET;
      tpe_r       <= ssrp_pkg::TPE_RESET;
      e0v_r       <= 1'b0;
      reads_r     <= '0;
      start_chk_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      ri_r        <= ri_nxt;
      bc_r        <= bc_nxt;
      bl_r        <= bl_nxt;
      prog_r      <= prog_nxt;
      wi_r        <= wi_nxt;
      nl_r        <= nl_nxt;
      tpb_r       <= tpb_nxt;
      tpe_r       <= tpe_nxt;
      e0v_r       <= e0v_nxt;
      reads_r     <= reads_nxt;
      start_chk_r <= start_chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    muted_r    <= muted_nxt;
    ovr_r      <= ovr_nxt;
    nv_r       <= nv_nxt;
    nkey_r     <= nkey_nxt;
    mon_r      <= mon_nxt;
    moff_r     <= moff_nxt;
    out_data_r <= out_data_nxt;
  end

  `SSRP_ASSERT_IMP(a_write_only_when_programming,
                   ram_we,
                   (state_r == S_CLOSE || state_r == S_RLEN || state_r == S_UNM ||
                    state_r == S_KEY || state_r == S_END) && prog_r,
                   "store written outside a programming step")
  `SSRP_ASSERT_IMP(a_read_walk_bounded, 1'b1, reads_r <= READS_MAX,
                   "record walk read more tokens than the store allows")
  `SSRP_ASSERT_IMP(a_read_index_in_range, 1'b1, ri_r <= LAST_IDX,
                   "read index beyond the store")
  `SSRP_ASSERT_NXT(a_result_loaded,
                   state_r == S_DONE && (!out_valid_r || out_ready),
                   out_valid_r && state_r == S_IDLE,
                   "finished item did not reach the output register")

endmodule

`default_nettype wire
